@@ hdl/tgarle_pkg.sv @@
// Shared types, register map and constants of the TGA run-length decoder.
package tgarle_pkg;

	localparam int PIXEL_COUNT_BITS_DEF = 32;

	localparam int BPP_W   = 3;
	localparam int TOTAL_W = 32;
	localparam int PIXEL_W = 32;
	localparam int REP_W   = 8;

	localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd3;
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 32'd1;

	localparam logic [BPP_W-1:0] BPP_MIN = 3'd1;
	localparam logic [BPP_W-1:0] BPP_MAX = 3'd4;

	// Packet header coding
	localparam logic [7:0] RUN_BIAS = 8'd127;

	// Register index, taken from paddr[2]
	localparam logic REG_BPP   = 1'b0;
	localparam logic REG_TOTAL = 1'b1;

	typedef struct packed {
		logic [BPP_W-1:0]   bpp;
		logic [TOTAL_W-1:0] total;
	} cfg_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic [REP_W-1:0]   rep;
		logic               last;
		logic               ovf;
	} res_t;

endpackage

@@ hdl/tgarle_cfg.sv @@
// APB-style register file holding bytes per pixel and the image pixel count.
module tgarle_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output tgarle_pkg::cfg_t  cfg
);

	logic [tgarle_pkg::BPP_W-1:0]   bpp_q;
	logic [tgarle_pkg::TOTAL_W-1:0] total_q;
	logic                           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q   <= tgarle_pkg::BPP_RESET;
			total_q <= tgarle_pkg::TOTAL_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				tgarle_pkg::REG_BPP:   bpp_q   <= pwdata[tgarle_pkg::BPP_W-1:0];
				tgarle_pkg::REG_TOTAL: total_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			tgarle_pkg::REG_BPP:   prdata = {29'd0, bpp_q};
			tgarle_pkg::REG_TOTAL: prdata = total_q;
			default:               prdata = '0;
		endcase
	end

	assign cfg.bpp   = bpp_q;
	assign cfg.total = total_q;

endmodule

@@ hdl/tgarle_dec.sv @@
// Packet parser, pixel assembly and pixel counting; one byte per accepted transfer.
module tgarle_dec #(
	parameter int PIXEL_COUNT_BITS = tgarle_pkg::PIXEL_COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        byte_in,
	input  logic              start_of_image,
	input  tgarle_pkg::cfg_t  cfg,
	output logic              res_valid,
	output tgarle_pkg::res_t  res
);

	localparam int CW = PIXEL_COUNT_BITS;

	logic          body_q, run_q, fin_q;
	logic [7:0]    left_q;
	logic [1:0]    bip_q;
	logic [31:0]   asm_q;
	logic [CW-1:0] done_q;

	logic          n_body, n_run, n_fin;
	logic [7:0]    n_left;
	logic [1:0]    n_bip;
	logic [31:0]   n_asm;
	logic [CW-1:0] n_done;

	always_comb begin
		logic          c_body, c_run, c_fin;
		logic [7:0]    c_left, left_dec;
		logic [1:0]    c_bip;
		logic [31:0]   c_asm, shifted, asm_new;
		logic [CW-1:0] c_done, total, missing, done_inc, done_run;
		logic [2:0]    bpp_eff;

		n_body    = body_q;
		n_run     = run_q;
		n_fin     = fin_q;
		n_left    = left_q;
		n_bip     = bip_q;
		n_asm     = asm_q;
		n_done    = done_q;
		res_valid = 1'b0;
		res       = '0;

		// start of image clears the stream state ahead of this byte
		c_body = start_of_image ? 1'b0 : body_q;
		c_run  = start_of_image ? 1'b0 : run_q;
		c_fin  = start_of_image ? 1'b0 : fin_q;
		c_left = start_of_image ? 8'd0 : left_q;
		c_bip  = start_of_image ? 2'd0 : bip_q;
		c_asm  = start_of_image ? 32'd0 : asm_q;
		c_done = start_of_image ? '0 : done_q;

		if (cfg.bpp == 3'd0)
			bpp_eff = tgarle_pkg::BPP_MIN;
		else if (cfg.bpp > tgarle_pkg::BPP_MAX)
			bpp_eff = tgarle_pkg::BPP_MAX;
		else
			bpp_eff = cfg.bpp;

		case (c_bip)
			2'd0:    shifted = {24'd0, byte_in};
			2'd1:    shifted = {16'd0, byte_in, 8'd0};
			2'd2:    shifted = {8'd0, byte_in, 16'd0};
			default: shifted = {byte_in, 24'd0};
		endcase
		asm_new = c_asm | shifted;

		total    = cfg.total[CW-1:0];
		missing  = (total > c_done) ? (total - c_done) : '0;
		done_inc = c_done + CW'(1);
		done_run = c_done + CW'(c_left);
		left_dec = (c_left != 8'd0) ? (c_left - 8'd1) : 8'd0;

		if (in_valid) begin
			n_body = c_body;
			n_run  = c_run;
			n_fin  = c_fin;
			n_left = c_left;
			n_bip  = c_bip;
			n_asm  = c_asm;
			n_done = c_done;
			if (!c_fin) begin
				if (!c_body) begin
					// packet header
					n_run  = byte_in[7];
					n_left = byte_in[7] ? (byte_in - tgarle_pkg::RUN_BIAS) : (byte_in + 8'd1);
					n_body = 1'b1;
					n_bip  = 2'd0;
					n_asm  = 32'd0;
				end else if (({1'b0, c_bip} + 3'd1) < bpp_eff) begin
					n_bip = c_bip + 2'd1;
					n_asm = asm_new;
				end else begin
					n_bip     = 2'd0;
					n_asm     = 32'd0;
					res_valid = 1'b1;
					if (c_run) begin
						n_left = 8'd0;
						n_body = 1'b0;
						if (CW'(c_left) > missing) begin
							// clip the run to what is still missing
							n_done   = total;
							res.rep  = missing[7:0];
							res.last = 1'b1;
							res.ovf  = 1'b1;
						end else begin
							n_done   = done_run;
							res.rep  = c_left;
							res.last = (done_run == total);
						end
					end else begin
						n_left = left_dec;
						n_body = (left_dec != 8'd0);
						if (missing == '0) begin
							// drop the extra raw pixel
							res.last = 1'b1;
							res.ovf  = 1'b1;
						end else begin
							n_done   = done_inc;
							res.rep  = 8'd1;
							res.last = (done_inc == total) && (left_dec == 8'd0);
						end
					end
					res.pixel = (res.rep == 8'd0) ? 32'd0 : asm_new;
					if (res.last)
						n_fin = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_q <= 1'b0;
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			left_q <= 8'd0;
			bip_q  <= 2'd0;
			asm_q  <= 32'd0;
			done_q <= '0;
		end else begin
			body_q <= n_body;
			run_q  <= n_run;
			fin_q  <= n_fin;
			left_q <= n_left;
			bip_q  <= n_bip;
			asm_q  <= n_asm;
			done_q <= n_done;
		end
	end

	a_ovf_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.ovf |-> res.last)
		else $error("overflow result not marked last");

	a_zero_rep: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.rep == 8'd0 |-> res.pixel == 32'd0 && res.ovf)
		else $error("zero repeat without overflow or with nonzero pixel");

	a_fin_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q && in_valid && !start_of_image |-> !res_valid)
		else $error("result after image end");

	a_last_sets_fin: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |=> fin_q)
		else $error("last result did not stop the decoder");

endmodule

@@ hdl/tgarle_obuf.sv @@
// Two-entry result buffer between the decoder and the output stream.
module tgarle_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tgarle_pkg::res_t  din,
	output logic              full,
	output logic              m_valid,
	input  logic              m_ready,
	output tgarle_pkg::res_t  dout
);

	tgarle_pkg::res_t mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign full    = (cnt_q == 2'd2);
	assign m_valid = (cnt_q != 2'd0);
	assign pop     = m_valid & m_ready;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full result buffer");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("result count lost a push");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("buffer pointers out of step");

endmodule

@@ hdl/tga_rle_decoder_core.sv @@
// Top level of the TGA run-length decoder: register port, decoder and result buffer.
//
// Input stream: one coded byte per transfer on s_tdata; s_tuser set on the
// first byte of an image (a packet header) clears the pixel counters.
// Output stream: one result per finished pixel or run; m_tdata carries the
// pixel and its repeat count, m_tlast marks the result that completes or
// ends the image, m_tuser flags overflow past total_pixels.
// Headers and non-final bytes of a pixel produce no result.
// Results: the result of the byte that completes it is registered in the
// result buffer, and m_tvalid is taken from the buffer's count register.
// Throughput: one byte per cycle while the buffer is not full; the decode
// step is a single pass of logic between the stream state registers and a
// two-entry result buffer. Stalls: while m_tready is low the buffer holds
// up to two results and s_tready stays high until it is full.
// After the last result, bytes are taken and dropped until s_tuser is set.
// Reset: arst_n clears the stream state and the buffer; bytes_per_pixel
// returns to 3 and total_pixels to 1. Write registers only while idle.
module tga_rle_decoder_core #(
	parameter int PIXEL_COUNT_BITS = tgarle_pkg::PIXEL_COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic        s_tuser,   // [0] start_of_image
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] pixel, [39:32] repeat_res
	output logic        m_tlast,   // last_pixel
	output logic        m_tuser    // [0] overflow
);

	tgarle_pkg::cfg_t cfg;
	tgarle_pkg::res_t res, res_out;
	logic             res_valid, buf_full, in_xfer;

	assign s_tready = ~buf_full;
	assign in_xfer  = s_tvalid & s_tready;

	tgarle_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tgarle_dec #(
		.PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
	) u_dec (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_xfer),
		.byte_in        (s_tdata),
		.start_of_image (s_tuser),
		.cfg            (cfg),
		.res_valid      (res_valid),
		.res            (res)
	);

	tgarle_obuf u_obuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_valid),
		.din     (res),
		.full    (buf_full),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.dout    (res_out)
	);

	assign m_tdata = {res_out.rep, res_out.pixel};
	assign m_tlast = res_out.last;
	assign m_tuser = res_out.ovf;

endmodule
